/* src/klsir_pkg.sv */
// Package for the key table block: request and response structs, operation
// codes and register indexes. No dependencies.
`default_nettype none
package klsir_pkg;

    localparam int KEY_W = 31;
    localparam int OUT_W = 7;
    localparam int CFG_W = 32;

    // Operation codes carried in the request
    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Register indexes (word address bit 2)
    localparam logic REG_ORDERED  = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    localparam logic       ORDERED_RESET  = 1'b1;
    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic             success;
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] entry_count;
    } t_rsp;

endpackage
`default_nettype wire

/* src/key_list_search_insert_remove_top.sv */
// Key table with search, insert and remove; depends on klsir_pkg.
// Ordered mode runs a binary search (issue probe, then compare probe); unordered mode runs
// a linear search. An unordered insert then appends, an unordered remove moves the last
// entry into the freed slot, and an ordered insert or remove shifts the entries in between.
// One request in flight; the next is taken the cycle after its result is registered.
// Reset (synchronous, active low) empties the table and restores registers.
`default_nettype none
module key_list_search_insert_remove_top
    import klsir_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_req        i_in_data,
    // response channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_rsp             o_out_data,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [CFG_W-1:0] pwdata,
    output logic [CFG_W-1:0] prdata,
    output logic             pready
);

    // Address width for the memory, count width able to hold DEPTH itself
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > OUT_W) ? CW : OUT_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BS_RD  = 4'd1;   // binary search: issue probe
    localparam logic [3:0] S_BS_CMP = 4'd2;   // binary search: compare probe
    localparam logic [3:0] S_LS     = 4'd3;   // linear search, one read a cycle
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_SHU    = 4'd5;   // shift entries up for insert
    localparam logic [3:0] S_SHD    = 4'd6;   // shift entries down for remove
    localparam logic [3:0] S_RM_RD  = 4'd7;   // unordered remove: read last
    localparam logic [3:0] S_RM_WR  = 4'd8;   // unordered remove: fill hole
    localparam logic [3:0] S_APPEND = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // Key memory: one read port (registered data), one write port
    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    // Control and working registers
    logic [3:0]    r_state,     n_state;
    logic [CW-1:0] r_count,     n_count;
    logic          r_ordered,   n_ordered;
    logic [6:0]    r_capacity,  n_capacity;
    t_req          r_req,       n_req;
    logic [CW-1:0] r_lo,        n_lo;
    logic [CW-1:0] r_hi,        n_hi;
    logic [CW-1:0] r_mid,       n_mid;
    logic [CW-1:0] r_idx,       n_idx;
    logic          r_pend,      n_pend;
    logic [CW-1:0] r_pdest,     n_pdest;
    logic          r_found,     n_found;
    logic [CW-1:0] r_pos,       n_pos;
    logic          r_ok,        n_ok;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out,       n_out;

    logic          cfg_wr;
    logic          in_acc;
    logic          full;
    logic [CW-1:0] mid;
    logic [CW-1:0] idx_m1;
    logic [CW-1:0] cnt_m1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    // Midpoint of the live search window; idx and count minus one for shifts
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_m1 = r_idx - CW'(1);
    assign cnt_m1 = r_count - CW'(1);

    // Table full at the smaller of the capacity register and DEPTH
    assign full = (r_count >= CW'(DEPTH)) || (WW'(r_count) >= WW'(r_capacity));

    // Register read-back
    always_comb begin
        unique case (paddr[2])
            REG_ORDERED:  prdata = {{(CFG_W-1){1'b0}}, r_ordered};
            REG_CAPACITY: prdata = {{(CFG_W-7){1'b0}}, r_capacity};
            default:      prdata = '0;
        endcase
    end

    // Sequencer. Shifts walk in the direction that keeps every read ahead of
    // the write it feeds, so a read never hits the entry written that cycle.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ordered   = r_ordered;
        n_capacity  = r_capacity;
        n_req       = r_req;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pdest     = r_pdest;
        n_found     = r_found;
        n_pos       = r_pos;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = r_req.key;

        // Drop the held result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // Take register writes; the host must issue them only while no request is in flight (not enforced here)
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_ORDERED:  n_ordered  = pwdata[0];
                REG_CAPACITY: n_capacity = pwdata[6:0];
                default:      ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req   = i_in_data;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_ok    = 1'b0;
                    if (i_in_data.mode != OP_SEARCH && i_in_data.mode != OP_INSERT &&
                        i_in_data.mode != OP_REMOVE) begin
                        n_state = S_DECIDE;
                    end else if (r_ordered) begin
                        n_state = S_BS_RD;
                    end else begin
                        n_state = S_LS;
                    end
                end
            end

            S_BS_RD: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = mid[AW-1:0];
                    n_mid   = mid;
                    n_state = S_BS_CMP;
                end else begin
                    // Window closed: key absent, lo is the insertion point
                    n_found = 1'b0;
                    n_pos   = r_lo;
                    n_state = S_DECIDE;
                end
            end

            S_BS_CMP: begin
                if (r_rdata < r_req.key) begin
                    n_lo    = r_mid + CW'(1);
                    n_state = S_BS_RD;
                end else if (r_rdata > r_req.key) begin
                    n_hi    = r_mid;
                    n_state = S_BS_RD;
                end else begin
                    n_found = 1'b1;
                    n_pos   = r_mid;
                    n_state = S_DECIDE;
                end
            end

            S_LS: begin
                // Compare last cycle's read while issuing the next one
                if (r_pend && (r_rdata == r_req.key)) begin
                    n_found = 1'b1;
                    n_pos   = r_pdest;
                    n_pend  = 1'b0;
                    n_state = S_DECIDE;
                end else if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_pend  = 1'b1;
                    n_pdest = r_idx;
                    n_idx   = r_idx + CW'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_found = 1'b0;
                    n_pos   = r_count;
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                unique case (r_req.mode)
                    OP_SEARCH: begin
                        n_ok    = r_found;
                        n_state = S_DONE;
                    end
                    OP_INSERT: begin
                        if (!full && !r_found) begin
                            n_pend  = 1'b0;
                            n_idx   = r_count;
                            n_state = r_ordered ? S_SHU : S_APPEND;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_REMOVE: begin
                        if ((r_count != '0) && r_found) begin
                            n_pend  = 1'b0;
                            n_idx   = r_pos + CW'(1);
                            n_state = r_ordered ? S_SHD : S_RM_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_pos   = '0;
                        n_state = S_DONE;
                    end
                endcase
            end

            S_SHU: begin
                // Move entry idx-1 to idx, walking down to the insertion point
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pdest[AW-1:0];
                    wr_data = r_rdata;
                    n_pend  = 1'b0;
                end
                if (r_idx > r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m1[AW-1:0];
                    n_pend  = 1'b1;
                    n_pdest = r_idx;
                    n_idx   = idx_m1;
                end else if (!r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = r_req.key;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_SHD: begin
                // Move entry idx to idx-1, walking up to the last entry
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pdest[AW-1:0];
                    wr_data = r_rdata;
                    n_pend  = 1'b0;
                end
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_pend  = 1'b1;
                    n_pdest = idx_m1;
                    n_idx   = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_count = cnt_m1;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_RM_RD: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
                n_state = S_RM_WR;
            end

            S_RM_WR: begin
                // Last entry fills the freed slot
                wr_en   = 1'b1;
                wr_addr = r_pos[AW-1:0];
                wr_data = r_rdata;
                n_count = cnt_m1;
                n_ok    = 1'b1;
                n_state = S_DONE;
            end

            S_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = r_count[AW-1:0];
                wr_data = r_req.key;
                n_count = r_count + CW'(1);
                n_ok    = 1'b1;
                n_state = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free, then load the result
                if (!r_out_valid || i_out_ready) begin
                    n_out.success     = r_ok;
                    n_out.position    = OUT_W'(r_pos);
                    n_out.entry_count = OUT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Key memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ordered   <= ORDERED_RESET;
            r_capacity  <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ordered   <= n_ordered;
            r_capacity  <= n_capacity;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_idx   <= n_idx;
        r_pdest <= n_pdest;
        r_found <= n_found;
        r_pos   <= n_pos;
        r_ok    <= n_ok;
        r_out   <= n_out;
    end

endmodule
`default_nettype wire
